@@ rtl/mipmap_box_downsample_assert.svh @@
// Assertion macros for the top level of the mipmap box downsampler.
`ifndef MIPMAP_BOX_DOWNSAMPLE_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbd assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbd assertion failed");

`endif

@@ rtl/mbd_pkg.sv @@
// Package with the shared widths and types of the mipmap box downsampler.
package mbd_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int CONFIG_RESET      = 4096;
   localparam int DIM_W             = 13;
   localparam int ROW_W             = 12;
   localparam int DX_W              = 12;
   localparam int COORD_W           = 11;
   localparam int CSR_INDEX_W       = 2;
   localparam int COUNT_W           = 4;
   localparam int PART_W            = SAMPLE_BITS + 2;
   localparam int SUM_W             = SAMPLE_BITS + 4;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QCOUNT_W          = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
   } pixel_type;

   typedef struct packed {
      logic               first_col;
      logic               last_col;
      logic               first_row;
      logic               emit;
      logic               level_done;
      logic [COUNT_W-1:0] count;
      logic [DX_W-1:0]    dx;
      logic [COORD_W-1:0] dy;
   } tag_type;

   typedef struct packed {
      pixel_type pixel;
      tag_type   tag;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [QCOUNT_W-1:0] count;
   } qstat_type;

endpackage

@@ rtl/mbd_ifs.sv @@
// Handshake interfaces for the pixel, result and register write channels.
interface mbd_pix_if import mbd_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type red_in;
   sample_type green_in;
   sample_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
endinterface

interface mbd_rsp_if import mbd_pkg::*; ();
   logic               valid;
   logic               ready;
   sample_type         red_out;
   sample_type         green_out;
   sample_type         blue_out;
   logic [COORD_W-1:0] dest_x;
   logic [COORD_W-1:0] dest_y;
   logic               level_done;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output dest_x, output dest_y, output level_done, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input dest_x, input dest_y, input level_done, output ready);
endinterface

interface mbd_csr_if import mbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DIM_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/mbd_queue.sv @@
// Short item queue between the classifying front end and the filtering back end.
module mbd_queue import mbd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      push_ready,
   input  logic      pop,
   output item_type  head,
   output qstat_type stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   item_type            slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_item;
      end
   end

   assign head       = slots[rd_ptr_ff];
   assign push_ready = (count_ff != QCOUNT_W'(QUEUE_DEPTH));
   assign stat.valid = (count_ff != '0);
   assign stat.count = count_ff;

endmodule

@@ rtl/mbd_front.sv @@
// Front end: level geometry registers, source position tracking and block classification.
module mbd_front import mbd_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   mbd_pix_if.sink  req_pix,
   mbd_csr_if.sink  csr_wr,
   input  logic     q_ready,
   output logic     q_push,
   output item_type q_item
);

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [DIM_W-1:0] last;
      logic [DIM_W-2:0] dest_last;
      logic [1:0]       span;
   } dim_type;

   dim_type            width_geo_ff, width_geo_in;
   dim_type            height_geo_ff, height_geo_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic               csr_write;
   logic               accept;
   logic [DX_W-1:0]    dx_raw, dx;
   logic [COORD_W-1:0] dy_raw, dy;
   logic               dx_at_last, dy_at_last;
   logic               last_col, last_row;
   logic [1:0]         ncols, nrows;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int limit);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (32'(v) > limit) r = DIM_W'(limit);
      else r = v;
      return r;
   endfunction

   function automatic dim_type derive_dim(input logic [DIM_W-1:0] size);
      dim_type          d;
      logic [DIM_W-2:0] half_size;
      half_size   = size[DIM_W-1:1];
      d.last      = size - DIM_W'(1);
      d.dest_last = (half_size == '0) ? '0 : half_size - (DIM_W-1)'(1);
      d.span      = (size == DIM_W'(1)) ? 2'd1 : (size[0] ? 2'd3 : 2'd2);
      return d;
   endfunction

   assign csr_wr.ready  = 1'b1;
   assign req_pix.ready = q_ready;
   assign csr_write     = csr_wr.valid;
   assign accept        = req_pix.valid && q_ready;

   // A destination column or row that would start past the last one folds into it.
   always_comb begin
      dx_raw     = col_ff[DIM_W-1:1];
      dx_at_last = (dx_raw >= width_geo_ff.dest_last);
      dx         = dx_at_last ? width_geo_ff.dest_last : dx_raw;
      last_col   = dx_at_last ? (col_ff == width_geo_ff.last) : col_ff[0];
      ncols      = dx_at_last ? width_geo_ff.span : 2'd2;

      dy_raw     = row_ff[ROW_W-1:1];
      dy_at_last = ({1'b0, dy_raw} >= height_geo_ff.dest_last);
      dy         = dy_at_last ? height_geo_ff.dest_last[COORD_W-1:0] : dy_raw;
      last_row   = dy_at_last ? (row_ff == height_geo_ff.last[ROW_W-1:0]) : row_ff[0];
      nrows      = dy_at_last ? height_geo_ff.span : 2'd2;

      q_item.pixel.red      = req_pix.red_in;
      q_item.pixel.green    = req_pix.green_in;
      q_item.pixel.blue     = req_pix.blue_in;
      q_item.tag.first_col  = !col_ff[0] && (dx_raw <= width_geo_ff.dest_last);
      q_item.tag.last_col   = last_col;
      q_item.tag.first_row  = !row_ff[0] && ({1'b0, dy_raw} <= height_geo_ff.dest_last);
      q_item.tag.emit       = last_col && last_row;
      q_item.tag.level_done = dx_at_last && dy_at_last;
      q_item.tag.count      = COUNT_W'(ncols) * COUNT_W'(nrows);
      q_item.tag.dx         = dx;
      q_item.tag.dy         = dy;
   end

   assign q_push = accept;

   always_comb begin
      width_geo_in  = width_geo_ff;
      height_geo_in = height_geo_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      if (csr_write) begin
         case (csr_wr.index)
            CSR_SOURCE_WIDTH: begin
               width_geo_in = derive_dim(clamp_dim(csr_wr.data, MAX_WIDTH));
               col_in       = '0;
               row_in       = '0;
            end
            CSR_SOURCE_HEIGHT: begin
               height_geo_in = derive_dim(clamp_dim(csr_wr.data, HEIGHT_LIMIT));
               col_in        = '0;
               row_in        = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_ff == width_geo_ff.last) begin
            col_in = '0;
            row_in = (row_ff == height_geo_ff.last[ROW_W-1:0]) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_geo_ff  <= derive_dim(clamp_dim(DIM_W'(CONFIG_RESET), MAX_WIDTH));
         height_geo_ff <= derive_dim(clamp_dim(DIM_W'(CONFIG_RESET), HEIGHT_LIMIT));
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         width_geo_ff  <= width_geo_in;
         height_geo_ff <= height_geo_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

endmodule

@@ rtl/mbd_back.sv @@
// Back end: row sums, column sum memory, rounded division and the output register.
module mbd_back import mbd_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  qstat_type  q_stat,
   input  item_type   q_head,
   output logic       q_pop,
   mbd_rsp_if.source  rsp_pix
);

   localparam int DEST_COLS = MAX_WIDTH / 2;
   localparam int ADDR_W    = (DEST_COLS > 1) ? $clog2(DEST_COLS) : 1;
   localparam int PROD_W    = 2 * SUM_W;
   localparam logic [1:0] DIV_ONE   = 2'd0;
   localparam logic [1:0] DIV_THREE = 2'd1;
   localparam logic [1:0] DIV_NINE  = 2'd2;
   localparam logic [SUM_W-1:0] RECIP_THREE = SUM_W'((64'd1 << SUM_W) / 64'd3);
   localparam logic [SUM_W-1:0] RECIP_NINE  = SUM_W'((64'd1 << SUM_W) / 64'd9);

   typedef struct packed {
      logic [PART_W-1:0] red;
      logic [PART_W-1:0] green;
      logic [PART_W-1:0] blue;
   } part_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sums_type;

   typedef struct packed {
      logic [2:0] half;
      logic [1:0] shift;
      logic [1:0] sel;
   } plan_type;

   typedef struct packed {
      logic [SUM_W-1:0] quot;
      logic [SUM_W-1:0] val;
   } est_type;

   typedef struct packed {
      est_type red;
      est_type green;
      est_type blue;
   } est3_type;

   typedef struct packed {
      logic               level_done;
      logic [DX_W-1:0]    dx;
      logic [COORD_W-1:0] dy;
   } place_type;

   sums_type           col_mem [DEST_COLS];

   logic               en;
   logic [ADDR_W-1:0]  rd_addr;
   part_type           partial_ff, partial_in;
   sums_type           rdata_ff;

   logic               s1_valid_ff, s1_valid_in;
   part_type           s1_partial_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_first_row_ff;
   logic               s1_emit_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   place_type          s1_place_ff;
   sums_type           base;
   sums_type           colsum_in;

   logic               lastw_valid_ff;
   logic [ADDR_W-1:0]  lastw_addr_ff;
   sums_type           lastw_data_ff;

   logic               s2_valid_ff, s2_valid_in;
   sums_type           s2_sum_ff;
   plan_type           s2_plan_ff;
   place_type          s2_place_ff;
   est3_type           est_in;

   logic               s3_valid_ff;
   est3_type           s3_est_ff;
   logic [1:0]         s3_sel_ff;
   place_type          s3_place_ff;

   logic               rsp_valid_ff;
   pixel_type          out_pixel_ff, out_pixel_in;
   place_type          out_place_ff;

   function automatic logic [PART_W-1:0] part_next(input logic first,
                                                   input logic [PART_W-1:0] prev,
                                                   input sample_type sample);
      return first ? PART_W'(sample) : prev + PART_W'(sample);
   endfunction

   function automatic logic [SUM_W-1:0] col_next(input logic first,
                                                 input logic [SUM_W-1:0] prev,
                                                 input logic [PART_W-1:0] part);
      return first ? SUM_W'(part) : prev + SUM_W'(part);
   endfunction

   function automatic plan_type div_plan(input logic [COUNT_W-1:0] count);
      plan_type p;
      case (count)
         COUNT_W'(1): p = '{half: 3'd0, shift: 2'd0, sel: DIV_ONE};
         COUNT_W'(2): p = '{half: 3'd1, shift: 2'd1, sel: DIV_ONE};
         COUNT_W'(3): p = '{half: 3'd1, shift: 2'd0, sel: DIV_THREE};
         COUNT_W'(4): p = '{half: 3'd2, shift: 2'd2, sel: DIV_ONE};
         COUNT_W'(6): p = '{half: 3'd3, shift: 2'd1, sel: DIV_THREE};
         COUNT_W'(9): p = '{half: 3'd4, shift: 2'd0, sel: DIV_NINE};
         default:     p = '{half: 3'd0, shift: 2'd0, sel: DIV_ONE};
      endcase
      return p;
   endfunction

   // The reciprocal estimate is low by at most one; the next stage corrects it.
   function automatic est_type estimate(input logic [SUM_W-1:0] sum, input plan_type plan);
      est_type          e;
      logic [SUM_W-1:0] recip;
      logic [PROD_W-1:0] prod;
      e.val  = (sum + SUM_W'(plan.half)) >> plan.shift;
      recip  = (plan.sel == DIV_NINE) ? RECIP_NINE : RECIP_THREE;
      prod   = PROD_W'(e.val) * PROD_W'(recip);
      e.quot = (plan.sel == DIV_ONE) ? e.val : prod[PROD_W-1:SUM_W];
      return e;
   endfunction

   function automatic sample_type correct(input est_type e, input logic [1:0] sel);
      logic [SUM_W-1:0] scaled;
      logic [SUM_W-1:0] divisor;
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] quot;
      case (sel)
         DIV_THREE: begin
            scaled  = e.quot + (e.quot << 1);
            divisor = SUM_W'(3);
         end
         DIV_NINE: begin
            scaled  = e.quot + (e.quot << 3);
            divisor = SUM_W'(9);
         end
         default: begin
            scaled  = e.quot;
            divisor = SUM_W'(1);
         end
      endcase
      rem  = e.val - scaled;
      quot = (rem >= divisor) ? e.quot + 1'b1 : e.quot;
      return quot[SAMPLE_BITS-1:0];
   endfunction

   assign en      = !rsp_valid_ff || rsp_pix.ready;
   assign q_pop   = en && q_stat.valid;
   assign rd_addr = ADDR_W'(q_head.tag.dx);

   always_comb begin
      partial_in.red   = part_next(q_head.tag.first_col, partial_ff.red, q_head.pixel.red);
      partial_in.green = part_next(q_head.tag.first_col, partial_ff.green,
                                   q_head.pixel.green);
      partial_in.blue  = part_next(q_head.tag.first_col, partial_ff.blue, q_head.pixel.blue);
      s1_valid_in      = q_pop && q_head.tag.last_col;
   end

   // The most recent write is forwarded over the memory word read in the same cycle.
   always_comb begin
      base = (lastw_valid_ff && (lastw_addr_ff == s1_addr_ff)) ? lastw_data_ff : rdata_ff;
      colsum_in.red   = col_next(s1_first_row_ff, base.red, s1_partial_ff.red);
      colsum_in.green = col_next(s1_first_row_ff, base.green, s1_partial_ff.green);
      colsum_in.blue  = col_next(s1_first_row_ff, base.blue, s1_partial_ff.blue);
      s2_valid_in     = s1_valid_ff && s1_emit_ff;
   end

   always_comb begin
      est_in.red   = estimate(s2_sum_ff.red, s2_plan_ff);
      est_in.green = estimate(s2_sum_ff.green, s2_plan_ff);
      est_in.blue  = estimate(s2_sum_ff.blue, s2_plan_ff);
   end

   always_comb begin
      out_pixel_in.red   = correct(s3_est_ff.red, s3_sel_ff);
      out_pixel_in.green = correct(s3_est_ff.green, s3_sel_ff);
      out_pixel_in.blue  = correct(s3_est_ff.blue, s3_sel_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         partial_ff <= partial_in;
      end
      if (s1_valid_in) begin
         rdata_ff <= col_mem[rd_addr];
      end
      if (en && s1_valid_ff) begin
         col_mem[s1_addr_ff] <= colsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         lastw_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
         if (s1_valid_ff) begin
            lastw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_partial_ff          <= partial_in;
         s1_addr_ff             <= rd_addr;
         s1_first_row_ff        <= q_head.tag.first_row;
         s1_emit_ff             <= q_head.tag.emit;
         s1_count_ff            <= q_head.tag.count;
         s1_place_ff.level_done <= q_head.tag.level_done;
         s1_place_ff.dx         <= q_head.tag.dx;
         s1_place_ff.dy         <= q_head.tag.dy;
         if (s1_valid_ff) begin
            lastw_addr_ff <= s1_addr_ff;
            lastw_data_ff <= colsum_in;
         end
         s2_sum_ff    <= colsum_in;
         s2_plan_ff   <= div_plan(s1_count_ff);
         s2_place_ff  <= s1_place_ff;
         s3_est_ff    <= est_in;
         s3_sel_ff    <= s2_plan_ff.sel;
         s3_place_ff  <= s2_place_ff;
         out_pixel_ff <= out_pixel_in;
         out_place_ff <= s3_place_ff;
      end
   end

   assign rsp_pix.valid      = rsp_valid_ff;
   assign rsp_pix.red_out    = out_pixel_ff.red;
   assign rsp_pix.green_out  = out_pixel_ff.green;
   assign rsp_pix.blue_out   = out_pixel_ff.blue;
   assign rsp_pix.dest_x     = out_place_ff.dx[COORD_W-1:0];
   assign rsp_pix.dest_y     = out_place_ff.dy;
   assign rsp_pix.level_done = out_place_ff.level_done;

endmodule

@@ rtl/mipmap_box_downsample.sv @@
// Top level of the mipmap box downsampler. It takes one source pixel per clock in raster
// order while the queue has room and emits the next mip level, each result the rounded
// average of a 2x2 block (3 wide or 3 tall at an odd last column or row, one sample wide
// or tall where the source is). The sustained rate is one pixel per cycle: the front end
// classifies each pixel in the cycle it arrives and the back end retires one queued pixel
// per cycle, pausing only while a result waits at the output. A result passes, after the
// transfer of the pixel that completes its block, through the column sum memory read as
// the queue hands the pixel on, the sum update, the reciprocal multiply and its correction
// into the output register. The column sum memory needs no clearing after reset, and a
// write to the width or height register restarts the level at pixel (0, 0).
`include "mipmap_box_downsample_assert.svh"

module mipmap_box_downsample import mbd_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   mbd_pix_if.sink   req_pix,
   mbd_rsp_if.source rsp_pix,
   mbd_csr_if.sink   csr_wr
);

   logic      q_push;
   logic      q_ready;
   logic      q_pop;
   item_type  q_item;
   item_type  q_head;
   qstat_type q_stat;

   mbd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_pix (req_pix),
      .csr_wr  (csr_wr),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_item  (q_item)
   );

   mbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   mbd_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_pix (rsp_pix)
   );

   `MBD_ASSERT_NEXT(a_queue_grows, clock, reset, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1)
   `MBD_ASSERT_NEXT(a_queue_drains, clock, reset, q_pop && !q_push, q_stat.count == $past(q_stat.count) - 1'b1)
   `MBD_ASSERT_SAME(a_stall_holds_queue, clock, reset, rsp_pix.valid && !rsp_pix.ready, !q_pop)

endmodule
